/* src/lpf_pkg.sv */
// Shared types, constants and register codes for the lidar point filter.
// Used by every module of the block; depends on nothing.
package lpf_pkg;

   localparam int ANGLE_SHIFT = 1;
   localparam int MAX_POINTS  = 4096;
   localparam int INDEX_CAP   = 4095;
   localparam int QUEUE_DEPTH = 4;

   localparam int FULL_TURN = 23040;
   localparam int HALF_TURN = 11520;

   localparam int WORD_W   = 16;
   localparam int DIST_W   = 16;
   localparam int QUAL_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int ANGLE_W  = 15;
   localparam int RAW_W    = 18;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 56;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W    = 16;

   localparam logic [INDEX_W-1:0] INDEX_LIMIT =
      INDEX_W'(((MAX_POINTS - 1) < INDEX_CAP) ? (MAX_POINTS - 1) : INDEX_CAP);

   localparam logic [CSR_IDX_W-1:0] REG_MIN_RANGE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RANGE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_ANGLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ANGLE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANGLE_OFFS  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ORIENT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_LOW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IGNORE_HIGH = 3'd7;

   typedef struct packed {
      logic [DIST_W-1:0]         range_lo;
      logic [DIST_W-1:0]         range_hi;
      logic signed [ANGLE_W-1:0] emit_lo;
      logic signed [ANGLE_W-1:0] emit_hi;
      logic signed [CSR_W-1:0]   angle_offset;
      logic                      mirror;
      logic                      rotate;
      logic signed [ANGLE_W-1:0] ignore_low;
      logic signed [ANGLE_W-1:0] ignore_high;
   } cfg_type;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_angle;
      logic [DIST_W-1:0]       distance;
      logic [QUAL_W-1:0]       quality;
      logic [INDEX_W-1:0]      index;
   } entry_type;

endpackage

/* src/lpf_front.sv */
// Front end of the lidar point filter: takes request beats, forms the raw
// corrected angle and the scan index, and pushes an entry into the queue.
// Depends on lpf_pkg.
module lpf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [lpf_pkg::REQ_W-1:0] req_tdata, // angle_word, distance, quality
   input  logic                req_tlast,
   input  lpf_pkg::cfg_type    cfg,
   input  logic                q_full,
   output logic                q_push,
   output lpf_pkg::entry_type  q_entry
);

   logic [lpf_pkg::INDEX_W-1:0] scan_pos_ff;
   logic [lpf_pkg::INDEX_W-1:0] scan_pos_in;
   logic [lpf_pkg::WORD_W-1:0]  word;
   logic [lpf_pkg::WORD_W-1:0]  word_sh;
   logic signed [lpf_pkg::RAW_W-1:0] sum;
   logic signed [lpf_pkg::RAW_W-1:0] rot;
   logic accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept;

   assign word    = req_tdata[15:0];
   assign word_sh = word >> lpf_pkg::ANGLE_SHIFT;

   always_comb begin
      rot = cfg.rotate ? lpf_pkg::RAW_W'(lpf_pkg::HALF_TURN) : '0;
      sum = $signed({2'b00, word_sh})
            + {{(lpf_pkg::RAW_W-lpf_pkg::CSR_W){cfg.angle_offset[lpf_pkg::CSR_W-1]}},
               cfg.angle_offset}
            + rot;
      q_entry.raw_angle = cfg.mirror ? (lpf_pkg::RAW_W'(lpf_pkg::FULL_TURN) - sum) : sum;
      q_entry.distance  = req_tdata[31:16];
      q_entry.quality   = req_tdata[39:32];
      q_entry.index     = scan_pos_ff;
   end

   // Every beat takes an index; the count sticks at its limit until scan end.
   always_comb begin
      scan_pos_in = scan_pos_ff;
      if (accept) begin
         if (req_tlast) begin
            scan_pos_in = '0;
         end else if (scan_pos_ff < lpf_pkg::INDEX_LIMIT) begin
            scan_pos_in = scan_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff <= '0;
      end else begin
         scan_pos_ff <= scan_pos_in;
      end
   end

`ifndef ASSERT_OFF
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      scan_pos_ff <= lpf_pkg::INDEX_LIMIT)
      else $error("scan index beyond its limit");
   a_index_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (scan_pos_ff == '0))
      else $error("scan index not cleared after last beat");
`endif

endmodule

/* src/lpf_queue.sv */
// Short register queue between front and back ends of the point filter.
// Depends on lpf_pkg for the entry type.
module lpf_queue #(
   parameter int DEPTH = lpf_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lpf_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output lpf_pkg::entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lpf_pkg::entry_type      store_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");
`endif

endmodule

/* src/lpf_back.sv */
// Back end of the point filter: wraps the raw angle into one turn, applies
// the ignore, range and emit windows and holds the result beat.
// Depends on lpf_pkg.
module lpf_back (
   input  logic               clock,
   input  logic               reset,
   input  lpf_pkg::cfg_type   cfg,
   input  logic               q_valid,
   input  lpf_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // point_angle[14:0], point_range[30:15], point_intensity[38:31],
   // point_index[50:39], zero fill above
   output logic [lpf_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int NTHR = 9;

   logic                               s1_valid_ff, s1_valid_in;
   logic signed [lpf_pkg::ANGLE_W-1:0] s1_angle_ff, s1_angle_in;
   logic [lpf_pkg::DIST_W-1:0]         s1_dist_ff;
   logic [lpf_pkg::QUAL_W-1:0]         s1_qual_ff;
   logic [lpf_pkg::INDEX_W-1:0]        s1_index_ff;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [lpf_pkg::ANGLE_W-1:0] rsp_angle_ff;
   logic [lpf_pkg::DIST_W-1:0]         rsp_range_ff, rsp_range_in;
   logic [lpf_pkg::QUAL_W-1:0]         rsp_intens_ff, rsp_intens_in;
   logic [lpf_pkg::INDEX_W-1:0]        rsp_index_ff;

   logic                               out_free, s1_ready;
   logic [3:0]                         turns;
   logic [lpf_pkg::RAW_W-1:0]          turn_sub;
   logic signed [lpf_pkg::RAW_W:0]     wrapped;
   logic signed [lpf_pkg::RAW_W-1:0]   thr;
   logic                               ignored, in_limits, in_window;
   logic [lpf_pkg::DIST_W-1:0]         dist_ign;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_ready = !s1_valid_ff || out_free;
   assign q_pop    = q_valid && s1_ready;

   // Count the half-turn boundaries below the angle, then take off that
   // many whole turns; the boundaries cover more turns than the raw angle reaches.
   always_comb begin
      turns = '0;
      thr   = '0;
      for (int j = 0; j < NTHR; j++) begin
         thr = lpf_pkg::RAW_W'(lpf_pkg::HALF_TURN - 4 * lpf_pkg::FULL_TURN
                               + j * lpf_pkg::FULL_TURN);
         if (q_entry.raw_angle > thr) begin
            turns = turns + 1'b1;
         end
      end
      turn_sub = lpf_pkg::RAW_W'(turns) * lpf_pkg::RAW_W'(lpf_pkg::FULL_TURN);
      wrapped  = {q_entry.raw_angle[lpf_pkg::RAW_W-1], q_entry.raw_angle}
                 + (lpf_pkg::RAW_W+1)'(4 * lpf_pkg::FULL_TURN)
                 - $signed({1'b0, turn_sub});
      s1_angle_in = wrapped[lpf_pkg::ANGLE_W-1:0];
      s1_valid_in = s1_ready ? q_valid : s1_valid_ff;
   end

   always_comb begin
      ignored   = (s1_angle_ff >= cfg.ignore_low) && (s1_angle_ff <= cfg.ignore_high);
      dist_ign  = ignored ? '0 : s1_dist_ff;
      in_limits = (dist_ign >= cfg.range_lo) && (dist_ign <= cfg.range_hi);
      in_window = (s1_angle_ff >= cfg.emit_lo) && (s1_angle_ff <= cfg.emit_hi);
      rsp_range_in  = in_limits ? dist_ign : '0;
      rsp_intens_in = in_limits ? s1_qual_ff : '0;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff && in_window;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_angle_ff <= s1_angle_in;
         s1_dist_ff  <= q_entry.distance;
         s1_qual_ff  <= q_entry.quality;
         s1_index_ff <= q_entry.index;
      end
      if (out_free && s1_valid_ff) begin
         rsp_angle_ff  <= s1_angle_ff;
         rsp_range_ff  <= rsp_range_in;
         rsp_intens_ff <= rsp_intens_in;
         rsp_index_ff  <= s1_index_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_index_ff, rsp_intens_ff, rsp_range_ff, rsp_angle_ff};

`ifndef ASSERT_OFF
   a_angle_wrapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_angle_ff > -15'sd11520) && (rsp_angle_ff <= 15'sd11520)))
      else $error("result angle outside one turn");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

/* src/lidar_point_filter_unit.sv */
// Top level of the lidar point filter: register bank, front end, queue and
// back end. Depends on lpf_pkg, lpf_front, lpf_queue and lpf_back.
//
//   Channel  Direction  Beat contents
//   req_*    in         tdata: angle_word, distance, quality; tlast: scan_end
//   rsp_*    out        tdata: point_angle, point_range, point_intensity, point_index
//   csr_*    in         write enable, register index, write data
//
// One point is taken each cycle while the queue has room; only points that lie
// in the emit window appear as result beats.
// The front end turns a beat into a queue entry in the same cycle; the back
// end wraps the angle in one stage and filters into the output register in the next.
// Reset is synchronous and clears the queue, the pipeline, the scan index and
// the registers to their defaults; no further sweep follows it.
// A stalled result holds the back end; the queue keeps taking beats until full.
module lidar_point_filter_unit #(
   parameter int QUEUE_DEPTH = lpf_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // angle_word[15:0], distance[31:16], quality[39:32]
   input  logic [lpf_pkg::REQ_W-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // point_angle[14:0], point_range[30:15], point_intensity[38:31],
   // point_index[50:39], zero fill above
   output logic [lpf_pkg::RSP_W-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [lpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpf_pkg::CSR_W-1:0] csr_wdata
);

   lpf_pkg::cfg_type   cfg_ff, cfg_in;
   lpf_pkg::entry_type push_entry, head_entry;
   logic               q_full, q_push, q_pop, q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lpf_pkg::REG_MIN_RANGE:   cfg_in.range_lo     = csr_wdata;
            lpf_pkg::REG_MAX_RANGE:   cfg_in.range_hi     = csr_wdata;
            lpf_pkg::REG_MIN_ANGLE:   cfg_in.emit_lo      = csr_wdata[14:0];
            lpf_pkg::REG_MAX_ANGLE:   cfg_in.emit_hi      = csr_wdata[14:0];
            lpf_pkg::REG_ANGLE_OFFS:  cfg_in.angle_offset = csr_wdata;
            lpf_pkg::REG_ORIENT: begin
               cfg_in.rotate = csr_wdata[0];
               cfg_in.mirror = csr_wdata[1];
            end
            lpf_pkg::REG_IGNORE_LOW:  cfg_in.ignore_low   = csr_wdata[14:0];
            lpf_pkg::REG_IGNORE_HIGH: cfg_in.ignore_high  = csr_wdata[14:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_lo     <= 16'd1;
         cfg_ff.range_hi     <= 16'd64;
         cfg_ff.emit_lo      <= -15'sd11520;
         cfg_ff.emit_hi      <= 15'sd11520;
         cfg_ff.angle_offset <= '0;
         cfg_ff.rotate       <= 1'b0;
         cfg_ff.mirror       <= 1'b0;
         cfg_ff.ignore_low   <= 15'sd11520;
         cfg_ff.ignore_high  <= -15'sd11520;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   lpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (head_entry)
   );

   lpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* bench/lidar_point_filter_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the lidar point filter: follows register writes, predicts each
// emitted point from the request beats and compares it with the result beats.
// Depends on lpf_pkg for widths, register codes and the register bank layout.
module lidar_point_filter_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [lpf_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [lpf_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_we,
   input  logic [lpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpf_pkg::CSR_W-1:0]     csr_wdata,
   output int                            mismatches,
   output int                            points_pending,
   output int                            beats_seen,
   output int                            points_seen
);

   typedef struct packed {
      logic signed [lpf_pkg::ANGLE_W-1:0] angle;
      logic [lpf_pkg::DIST_W-1:0]         range;
      logic [lpf_pkg::QUAL_W-1:0]         intensity;
      logic [lpf_pkg::INDEX_W-1:0]        index;
   } filtered_point_type;

   lpf_pkg::cfg_type            regs;
   logic [lpf_pkg::INDEX_W-1:0] scan_index;
   filtered_point_type          expected_points[$];
   int                          n_bad    = 0;
   int                          n_beats  = 0;
   int                          n_points = 0;

   function automatic lpf_pkg::cfg_type default_regs();
      lpf_pkg::cfg_type c;
      c.range_lo     = lpf_pkg::DIST_W'(1);
      c.range_hi     = lpf_pkg::DIST_W'(64);
      c.emit_lo      = lpf_pkg::ANGLE_W'(-lpf_pkg::HALF_TURN);
      c.emit_hi      = lpf_pkg::ANGLE_W'(lpf_pkg::HALF_TURN);
      c.angle_offset = '0;
      c.mirror       = 1'b0;
      c.rotate       = 1'b0;
      c.ignore_low   = lpf_pkg::ANGLE_W'(lpf_pkg::HALF_TURN);
      c.ignore_high  = lpf_pkg::ANGLE_W'(-lpf_pkg::HALF_TURN);
      return c;
   endfunction

   // Corrects and wraps the angle, applies the ignore window and then the range
   // limits; returns whether the point falls inside the emit window.
   function automatic bit filter_point(input logic [lpf_pkg::WORD_W-1:0] word,
                                       input logic [lpf_pkg::DIST_W-1:0] meas_dist,
                                       input logic [lpf_pkg::QUAL_W-1:0] qual,
                                       input logic [lpf_pkg::INDEX_W-1:0] idx,
                                       output filtered_point_type pt);
      int                         a;
      int                         ig_lo;
      int                         ig_hi;
      int                         win_lo;
      int                         win_hi;
      logic [lpf_pkg::DIST_W-1:0] r;
      logic [lpf_pkg::QUAL_W-1:0] q;
      ig_lo  = $signed(regs.ignore_low);
      ig_hi  = $signed(regs.ignore_high);
      win_lo = $signed(regs.emit_lo);
      win_hi = $signed(regs.emit_hi);
      a = int'(word >> lpf_pkg::ANGLE_SHIFT) + int'($signed(regs.angle_offset));
      if (regs.rotate) a += lpf_pkg::HALF_TURN;
      if (regs.mirror) a = lpf_pkg::FULL_TURN - a;
      a = a % lpf_pkg::FULL_TURN;
      if (a < 0) a += lpf_pkg::FULL_TURN;
      if (a > lpf_pkg::HALF_TURN) a -= lpf_pkg::FULL_TURN;
      r = meas_dist;
      q = qual;
      if (a >= ig_lo && a <= ig_hi) r = '0;
      // The range test sees the range after the ignore window has cleared it.
      if (!(r >= regs.range_lo && r <= regs.range_hi)) begin
         r = '0;
         q = '0;
      end
      pt.angle     = lpf_pkg::ANGLE_W'(a);
      pt.range     = r;
      pt.intensity = q;
      pt.index     = idx;
      return (a >= win_lo && a <= win_hi);
   endfunction

   always @(posedge clock) begin : watch
      filtered_point_type got;
      filtered_point_type want;
      filtered_point_type pt;
      if (reset) begin
         regs       = default_regs();
         scan_index = '0;
         expected_points.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               lpf_pkg::REG_MIN_RANGE:   regs.range_lo     = csr_wdata;
               lpf_pkg::REG_MAX_RANGE:   regs.range_hi     = csr_wdata;
               lpf_pkg::REG_MIN_ANGLE:   regs.emit_lo      = csr_wdata[lpf_pkg::ANGLE_W-1:0];
               lpf_pkg::REG_MAX_ANGLE:   regs.emit_hi      = csr_wdata[lpf_pkg::ANGLE_W-1:0];
               lpf_pkg::REG_ANGLE_OFFS:  regs.angle_offset = csr_wdata;
               lpf_pkg::REG_ORIENT:      {regs.mirror, regs.rotate} = csr_wdata[1:0];
               lpf_pkg::REG_IGNORE_LOW:  regs.ignore_low   = csr_wdata[lpf_pkg::ANGLE_W-1:0];
               lpf_pkg::REG_IGNORE_HIGH: regs.ignore_high  = csr_wdata[lpf_pkg::ANGLE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            n_points++;
            got.angle     = rsp_tdata[14:0];
            got.range     = rsp_tdata[30:15];
            got.intensity = rsp_tdata[38:31];
            got.index     = rsp_tdata[50:39];
            if (expected_points.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("[%0t] unexpected point: angle %0d range %0d intensity %0d index %0d",
                           $realtime, got.angle, got.range, got.intensity, got.index);
            end else begin
               want = expected_points.pop_front();
               if (got.angle !== want.angle || got.range !== want.range ||
                   got.intensity !== want.intensity || got.index !== want.index) begin
                  n_bad++;
                  if (n_bad <= 10) begin
                     $display("[%0t] point %0d mismatch:", $realtime, n_points);
                     $display("   expected angle %0d range %0d intensity %0d index %0d",
                              want.angle, want.range, want.intensity, want.index);
                     $display("   actual   angle %0d range %0d intensity %0d index %0d",
                              got.angle, got.range, got.intensity, got.index);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            n_beats++;
            if (filter_point(req_tdata[15:0], req_tdata[31:16], req_tdata[39:32],
                             scan_index, pt))
               expected_points = {expected_points, pt};
            // Every beat takes an index; the end of a scan restarts the count.
            if (req_tlast)
               scan_index = '0;
            else if (scan_index < lpf_pkg::INDEX_LIMIT)
               scan_index++;
         end
      end
      mismatches     <= n_bad;
      points_pending <= expected_points.size();
      beats_seen     <= n_beats;
      points_seen    <= n_points;
   end

endmodule

/* bench/lidar_point_filter_unit_tb.sv */
`timescale 1ns / 1ps
// Top of the lidar point filter testbench: clock, reset, register settings,
// request stimulus and result back-pressure, and the verdict.
// Depends on lpf_pkg, lidar_point_filter_unit and lidar_point_filter_checker.
module lidar_point_filter_unit_tb;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_TAIL      = 12;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_BEATS     = 40;
   localparam int LONG_SCAN       = 60;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [lpf_pkg::REQ_W-1:0]     req_tdata  = '0;
   logic                          req_tlast  = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [lpf_pkg::RSP_W-1:0]     rsp_tdata;
   logic                          csr_we     = 1'b0;
   logic [lpf_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [lpf_pkg::CSR_W-1:0]     csr_wdata  = '0;

   int               mismatches;
   int               points_pending;
   int               beats_seen;
   int               points_seen;
   int               burst_left       = 0;
   int               settings_used    = 0;
   bit               hold_off_request = 1'b0;
   lpf_pkg::cfg_type active;

   lidar_point_filter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lidar_point_filter_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .points_pending (points_pending),
      .beats_seen     (beats_seen),
      .points_seen    (points_seen)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Offers one beat and returns at the edge that accepts it. Beats go out in
   // bursts; a gap is only opened before the first beat of a burst.
   task automatic send_point(input logic [lpf_pkg::WORD_W-1:0] word,
                             input logic [lpf_pkg::DIST_W-1:0] meas_dist,
                             input logic [lpf_pkg::QUAL_W-1:0] qual, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {qual, meas_dist, word};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   task automatic send_random_point(input bit may_end);
      logic [lpf_pkg::WORD_W-1:0] w;
      logic [lpf_pkg::DIST_W-1:0] d;
      logic [lpf_pkg::QUAL_W-1:0] q;
      logic                       e;
      case ($urandom_range(0, 7))
         0:       w = '0;
         1:       w = '1;
         2:       w = lpf_pkg::WORD_W'(lpf_pkg::FULL_TURN)
                      + lpf_pkg::WORD_W'($urandom_range(0, 4)) - lpf_pkg::WORD_W'(2);
         default: w = lpf_pkg::WORD_W'($urandom());
      endcase
      // Some distances cluster around the current limits so both edges get hit.
      case ($urandom_range(0, 7))
         0:       d = active.range_lo + lpf_pkg::DIST_W'($urandom_range(0, 2))
                      - lpf_pkg::DIST_W'(1);
         1:       d = active.range_hi + lpf_pkg::DIST_W'($urandom_range(0, 2))
                      - lpf_pkg::DIST_W'(1);
         2:       d = '0;
         3:       d = '1;
         default: d = lpf_pkg::DIST_W'($urandom());
      endcase
      q = lpf_pkg::QUAL_W'($urandom());
      e = may_end && ($urandom_range(0, 15) == 0);
      send_point(w, d, q, e);
   endtask

   // Stops offering beats, waits for every outstanding point and then lets
   // points that fall outside the emit window leave the pipeline as well.
   task automatic await_drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (points_pending != 0);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lpf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [lpf_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(input lpf_pkg::cfg_type c);
      write_reg(lpf_pkg::REG_MIN_RANGE, c.range_lo);
      write_reg(lpf_pkg::REG_MAX_RANGE, c.range_hi);
      write_reg(lpf_pkg::REG_MIN_ANGLE, lpf_pkg::CSR_W'(c.emit_lo));
      write_reg(lpf_pkg::REG_MAX_ANGLE, lpf_pkg::CSR_W'(c.emit_hi));
      write_reg(lpf_pkg::REG_ANGLE_OFFS, c.angle_offset);
      write_reg(lpf_pkg::REG_ORIENT, {14'd0, c.mirror, c.rotate});
      write_reg(lpf_pkg::REG_IGNORE_LOW, lpf_pkg::CSR_W'(c.ignore_low));
      write_reg(lpf_pkg::REG_IGNORE_HIGH, lpf_pkg::CSR_W'(c.ignore_high));
      csr_we <= 1'b0;
      active = c;
      settings_used++;
   endtask

   function automatic lpf_pkg::cfg_type open_setting();
      lpf_pkg::cfg_type c;
      c.range_lo     = '0;
      c.range_hi     = '1;
      c.emit_lo      = lpf_pkg::ANGLE_W'(-lpf_pkg::HALF_TURN);
      c.emit_hi      = lpf_pkg::ANGLE_W'(lpf_pkg::HALF_TURN);
      c.angle_offset = '0;
      c.mirror       = 1'b0;
      c.rotate       = 1'b0;
      c.ignore_low   = lpf_pkg::ANGLE_W'(lpf_pkg::HALF_TURN);
      c.ignore_high  = lpf_pkg::ANGLE_W'(-lpf_pkg::HALF_TURN);
      return c;
   endfunction

   function automatic lpf_pkg::cfg_type random_setting();
      lpf_pkg::cfg_type c;
      int               a;
      int               b;
      int               t;
      case ($urandom_range(0, 4))
         0: begin
            c.range_lo = '0;
            c.range_hi = '1;
         end
         1: begin
            c.range_lo = lpf_pkg::DIST_W'($urandom());
            c.range_hi = lpf_pkg::DIST_W'($urandom());
         end
         default: begin
            a = $urandom_range(0, 3000);
            c.range_lo = lpf_pkg::DIST_W'(a);
            c.range_hi = lpf_pkg::DIST_W'(a + int'($urandom_range(0, 5000)));
         end
      endcase
      a = int'($urandom_range(0, lpf_pkg::FULL_TURN)) - lpf_pkg::HALF_TURN;
      b = int'($urandom_range(0, lpf_pkg::FULL_TURN)) - lpf_pkg::HALF_TURN;
      if (a > b) begin
         t = a;
         a = b;
         b = t;
      end
      if ($urandom_range(0, 3) == 0) begin
         a = -lpf_pkg::HALF_TURN;
         b = lpf_pkg::HALF_TURN;
      end else if ($urandom_range(0, 9) == 0) begin
         t = a;
         a = b;
         b = t;
      end
      c.emit_lo = lpf_pkg::ANGLE_W'(a);
      c.emit_hi = lpf_pkg::ANGLE_W'(b);
      a = int'($urandom_range(0, lpf_pkg::FULL_TURN)) - lpf_pkg::HALF_TURN;
      b = a + int'($urandom_range(0, 4000));
      if (b > lpf_pkg::HALF_TURN) b = lpf_pkg::HALF_TURN;
      if ($urandom_range(0, 2) == 0) begin
         // High below low: nothing is ignored.
         t = a;
         a = b;
         b = t;
         if (a == b) begin
            a = lpf_pkg::HALF_TURN;
            b = -lpf_pkg::HALF_TURN;
         end
      end
      c.ignore_low  = lpf_pkg::ANGLE_W'(a);
      c.ignore_high = lpf_pkg::ANGLE_W'(b);
      case ($urandom_range(0, 5))
         0:       t = 0;
         1:       t = lpf_pkg::FULL_TURN;
         2:       t = -lpf_pkg::FULL_TURN;
         default: t = int'($urandom_range(0, 2 * lpf_pkg::FULL_TURN)) - lpf_pkg::FULL_TURN;
      endcase
      c.angle_offset = lpf_pkg::CSR_W'(t);
      {c.mirror, c.rotate} = 2'($urandom_range(0, 3));
      return c;
   endfunction

   // Result side: ready follows one of four patterns, each held for a random span,
   // and drops for a long stretch whenever a hold-off is requested.
   initial begin
      int mode;
      int left;
      int hold;
      int tick;
      mode = 0;
      left = 0;
      hold = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = HOLD_OFF_CYCLES;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(16, 96);
         end
         left--;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $realtime, idle);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      lpf_pkg::cfg_type s;
      int               ph;
      int               k;
      active = open_setting();
      active.range_lo = lpf_pkg::DIST_W'(1);
      active.range_hi = lpf_pkg::DIST_W'(64);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values: range window 1 to 64, full emit window.
      send_point(16'd0, 16'd0, 8'd0, 1'b0);         // zero range, intensity cleared
      send_point(16'hFFFF, 16'd1, 8'd255, 1'b0);    // largest word, smallest range
      send_point(16'd23040, 16'd64, 8'd128, 1'b0);  // exactly half a turn stays positive
      send_point(16'd23042, 16'd65, 8'd1, 1'b0);    // just past half a turn wraps negative
      send_point(16'd46080, 16'hFFFF, 8'h55, 1'b0); // full turn wraps to zero
      send_point(16'd2, 16'd32, 8'hAA, 1'b1);       // end of scan
      send_point(16'd1, 16'd10, 8'd7, 1'b0);        // index restarts
      await_drain();

      // Rotation with an offset of minus one full turn and an ignore window round zero.
      s = open_setting();
      s.angle_offset = lpf_pkg::CSR_W'(-lpf_pkg::FULL_TURN);
      s.rotate       = 1'b1;
      s.ignore_low   = lpf_pkg::ANGLE_W'(-640);
      s.ignore_high  = lpf_pkg::ANGLE_W'(640);
      apply_setting(s);
      send_point(16'd46080, 16'd500, 8'd3, 1'b0);
      send_point(16'd23040, 16'd500, 8'd4, 1'b0);   // ignored, intensity kept
      send_point(16'd24320, 16'd500, 8'd5, 1'b0);   // upper ignore bound is inclusive
      send_point(16'd24322, 16'd500, 8'd6, 1'b0);
      send_point(16'd0, 16'd0, 8'd255, 1'b0);
      await_drain();

      // Ignored point with a non-zero minimum range loses its intensity too.
      s.range_lo = lpf_pkg::DIST_W'(100);
      apply_setting(s);
      send_point(16'd23040, 16'd5000, 8'd200, 1'b0);
      await_drain();

      // Empty emit window under rotation, mirroring and an offset of one full turn.
      s = open_setting();
      s.mirror       = 1'b1;
      s.rotate       = 1'b1;
      s.angle_offset = lpf_pkg::CSR_W'(lpf_pkg::FULL_TURN);
      s.emit_lo      = lpf_pkg::ANGLE_W'(100);
      s.emit_hi      = lpf_pkg::ANGLE_W'(-100);
      apply_setting(s);
      send_point(16'd0, 16'd10, 8'd10, 1'b0);
      send_point(16'd1000, 16'd20, 8'd20, 1'b0);
      send_point(16'hFFFF, 16'd30, 8'd30, 1'b1);
      await_drain();

      // Mirror only, range pinned to the top value, emit window from zero up.
      s = open_setting();
      s.mirror   = 1'b1;
      s.emit_lo  = '0;
      s.range_lo = '1;
      s.range_hi = '1;
      apply_setting(s);
      send_point(16'd0, 16'hFFFF, 8'd255, 1'b0);
      send_point(16'd2, 16'hFFFF, 8'd1, 1'b0);      // mirrors to minus one, dropped
      send_point(16'd46078, 16'hFFFE, 8'd9, 1'b1);
      await_drain();

      // A long scan without an end marker, then a scan end and a fresh index.
      apply_setting(open_setting());
      for (k = 0; k < LONG_SCAN; k++)
         send_random_point(1'b0);
      send_point(lpf_pkg::WORD_W'($urandom()), lpf_pkg::DIST_W'($urandom()),
                 lpf_pkg::QUAL_W'($urandom()), 1'b1);
      send_point(lpf_pkg::WORD_W'($urandom()), lpf_pkg::DIST_W'($urandom()),
                 lpf_pkg::QUAL_W'($urandom()), 1'b0);
      await_drain();

      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin
               // Everything ignored, offset of one full turn, both orientation bits.
               s = open_setting();
               s.angle_offset = lpf_pkg::CSR_W'(lpf_pkg::FULL_TURN);
               {s.mirror, s.rotate} = 2'b11;
               s.ignore_low  = lpf_pkg::ANGLE_W'(-lpf_pkg::HALF_TURN);
               s.ignore_high = lpf_pkg::ANGLE_W'(lpf_pkg::HALF_TURN);
            end
            1: begin
               s = open_setting();
               s.angle_offset = lpf_pkg::CSR_W'(-lpf_pkg::FULL_TURN);
               s.rotate       = 1'b1;
               s.range_lo     = '1;
            end
            default: s = random_setting();
         endcase
         apply_setting(s);
         for (k = 0; k < PHASE_BEATS; k++) begin
            // Every point of this phase is emitted, so the hold-off fills the block.
            if (ph == 1 && k == 10) hold_off_request = 1'b1;
            send_random_point(1'b1);
         end
         await_drain();
      end

      $display("Sent %0d request beats and checked %0d points under %0d register settings,",
               beats_seen, points_seen, settings_used);
      $display("including a long scan, an empty emit window and a long result stall.");
      if (mismatches == 0 && points_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
src/lpf_pkg.sv
src/lpf_front.sv
src/lpf_queue.sv
src/lpf_back.sv
src/lidar_point_filter_unit.sv
bench/lidar_point_filter_checker.sv
bench/lidar_point_filter_unit_tb.sv
